// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Included by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion, active during reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ipd_pkg.sv =====
// Shared types, constants and the line-to-device range lookup
// for the interrupt pending dispatcher. No dependencies.
`default_nettype none

package ipd_pkg;

  localparam int LINES_PER_GROUP = 16;
  localparam int LINE_W          = 4;
  localparam int REG_COUNT       = 4;
  localparam int REG_W           = 24;
  localparam int REG_IDX_W       = 2;
  localparam int RANGE_CNT_W     = 3;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic REQ_CAPTURE = 1'b0;
  localparam logic REQ_SERVICE = 1'b1;

  typedef logic [REG_COUNT-1:0][REG_W-1:0] range_tbl_t;

  typedef struct packed {
    logic        is_service;
    logic        group_ok;
    logic [1:0]  group;
    logic [15:0] flags;
  } cmd_t;

  typedef struct packed {
    logic [7:0] dev_type;
    logic [7:0] dev_number;
    logic       err;
  } map_t;

  // Last valid entry, counted from entry 0, whose start is not above the line.
  function automatic map_t map_line(input logic [5:0] line, input range_tbl_t ent,
                                    input logic [RANGE_CNT_W-1:0] nranges);
    map_t               r;
    logic               stop;
    logic               found;
    logic [REG_IDX_W-1:0] sel;
    stop  = 1'b0;
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < REG_COUNT; i++) begin
      if (!stop) begin
        if ((RANGE_CNT_W'(i) >= nranges) || (ent[i][23:16] == 8'd0) ||
            (ent[i][7:0] > {2'b00, line})) begin
          stop = 1'b1;
        end else begin
          found = 1'b1;
          sel   = REG_IDX_W'(i);
        end
      end
    end
    if (found) begin
      r.dev_type   = ent[sel][23:16];
      r.dev_number = ent[sel][15:8] + {2'b00, line} - ent[sel][7:0];
      r.err        = 1'b0;
    end else begin
      r.dev_type   = 8'd0;
      r.dev_number = 8'd0;
      r.err        = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ipd_front.sv =====
// Front end: accepts input transactions and classifies them into commands.
// Depends on ipd_pkg.
`default_nettype none

module ipd_front #(
  parameter int NUM_GROUPS = 4
) (
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          req_type,
  input  wire logic [1:0]    group_index,
  input  wire logic [15:0]   line_flags,
  input  wire logic          q_full,
  output logic               q_push,
  output ipd_pkg::cmd_t      q_cmd
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.is_service = (req_type == ipd_pkg::REQ_SERVICE);
    q_cmd.group_ok   = (3'(group_index) < 3'(NUM_GROUPS));
    q_cmd.group      = group_index;
    q_cmd.flags      = line_flags;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ipd_queue.sv =====
// Short command queue between the front end and the dispatch engine.
// Depends on ipd_pkg.
`default_nettype none

module ipd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ipd_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output ipd_pkg::cmd_t      head_cmd,
  output logic               full,
  output logic               empty
);

  localparam int PW = (ipd_pkg::QUEUE_DEPTH > 1) ? $clog2(ipd_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(ipd_pkg::QUEUE_DEPTH + 1);

  ipd_pkg::cmd_t q_mem [ipd_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(ipd_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign head_cmd = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(ipd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(ipd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ipd_back.sv =====
// Dispatch engine: holds the pending words, applies captures and scans
// pending lines on service, one dispatch per cycle while the output does not stall. Depends on ipd_pkg.
`default_nettype none

module ipd_back #(
  parameter int NUM_GROUPS = 4,
  parameter int NUM_RANGES = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ipd_pkg::cmd_t       head_cmd,
  input  wire logic                q_empty,
  output logic                     q_pop,
  input  wire ipd_pkg::range_tbl_t ranges,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               device_type,
  output logic [7:0]               device_number,
  output logic [5:0]               line_number,
  output logic                     map_error,
  output logic                     last_dispatch
);

  localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t         state;
  logic [15:0]    pending [NUM_GROUPS];
  logic [GW-1:0]  grp;

  logic           out_ready;
  logic           fire;
  logic           any_pending;
  logic           higher_pending;
  logic [15:0]    cur_word;
  logic [15:0]    low_bit;
  logic [15:0]    cur_rest;
  logic [ipd_pkg::LINE_W-1:0] bit_idx;
  logic [5:0]     cur_line;
  logic           is_last;
  ipd_pkg::map_t  map_res;

  assign out_ready = !out_valid || !out_stall;
  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign fire      = (state == ST_SCAN) && (cur_word != 16'd0) && out_ready;

  always_comb begin
    any_pending    = 1'b0;
    higher_pending = 1'b0;
    for (int i = 0; i < NUM_GROUPS; i++) begin
      if (pending[i] != 16'd0) begin
        any_pending = 1'b1;
        if (GW'(i) > grp) begin
          higher_pending = 1'b1;
        end
      end
    end
  end

  always_comb begin
    cur_word = pending[grp];
    low_bit  = cur_word & (~cur_word + 16'd1);
    cur_rest = cur_word & ~low_bit;
    bit_idx  = '0;
    for (int i = 0; i < ipd_pkg::LINES_PER_GROUP; i++) begin
      if (low_bit[i]) begin
        bit_idx = bit_idx | ipd_pkg::LINE_W'(i);
      end
    end
    cur_line = (6'(grp) << ipd_pkg::LINE_W) | 6'(bit_idx);
    is_last  = (cur_rest == 16'd0) && !higher_pending;
    map_res  = ipd_pkg::map_line(cur_line, ranges, ipd_pkg::RANGE_CNT_W'(NUM_RANGES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      grp       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_GROUPS; i++) begin
        pending[i] <= 16'd0;
      end
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            if (!head_cmd.is_service) begin
              if (head_cmd.group_ok) begin
                pending[head_cmd.group[GW-1:0]] <=
                  pending[head_cmd.group[GW-1:0]] | head_cmd.flags;
              end
            end else if (any_pending) begin
              grp   <= '0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (cur_word == 16'd0) begin
            grp <= grp + 1'b1;
          end else if (out_ready) begin
            pending[grp]  <= cur_rest;
            device_type   <= map_res.dev_type;
            device_number <= map_res.dev_number;
            map_error     <= map_res.err;
            line_number   <= cur_line;
            last_dispatch <= is_last;
            if (is_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/interrupt_pending_dispatcher_core.sv =====
// Interrupt pending dispatcher, top level: configuration registers, front end,
// command queue and dispatch engine. Depends on ipd_pkg and the ipd_* modules.
//
// Capture transactions OR one group's flags into its pending word; service
// transactions emit one dispatch per pending line, ascending by line, with the
// last one marked. Input goes through a two-entry command queue, so the input
// side keeps taking transactions while the engine works or the output stalls,
// until the queue is full. A service run leaves idle, then steps through each
// dispatched line and through each group without a remaining pending line that
// the scan passes; the engine's single output register sets the rate of one
// dispatch per cycle while the output does not stall. A service with nothing
// pending emits nothing. The user must write the range table through cfg_write
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module interrupt_pending_dispatcher_core #(
  parameter int NUM_GROUPS = 4,
  parameter int NUM_RANGES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [1:0]  group_index,
  input  wire logic [15:0] line_flags,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       device_type,
  output logic [7:0]       device_number,
  output logic [5:0]       line_number,
  output logic             map_error,
  output logic             last_dispatch
);

  ipd_pkg::range_tbl_t ranges;
  ipd_pkg::cmd_t       push_cmd;
  ipd_pkg::cmd_t       head_cmd;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      ranges <= '0;
    end else if (cfg_write) begin
      ranges[cfg_index] <= cfg_data;
    end
  end

  ipd_front #(
    .NUM_GROUPS (NUM_GROUPS)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .group_index (group_index),
    .line_flags  (line_flags),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  ipd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  ipd_back #(
    .NUM_GROUPS (NUM_GROUPS),
    .NUM_RANGES (NUM_RANGES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_cmd      (head_cmd),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .ranges        (ranges),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .device_type   (device_type),
    .device_number (device_number),
    .line_number   (line_number),
    .map_error     (map_error),
    .last_dispatch (last_dispatch)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/ipd_checker.sv =====
// Port-level checks for the interrupt pending dispatcher, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ipd_checker #(
  parameter int NUM_GROUPS = 4
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] device_type,
  input wire logic [7:0] device_number,
  input wire logic [5:0] line_number,
  input wire logic       map_error,
  input wire logic       last_dispatch
);

  `ASSERT_RST(a_out_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(device_type) && $stable(device_number) && $stable(line_number) && $stable(map_error) && $stable(last_dispatch)), "stalled dispatch changed")

  `ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid, "dispatch valid right after reset")

  `ASSERT_RST(a_error_zero, clk, rst, (out_valid && map_error) |-> ((device_type == 8'd0) && (device_number == 8'd0)), "error dispatch carries device fields")

  `ASSERT_RST(a_line_range, clk, rst, out_valid |-> (7'(line_number) < 7'(NUM_GROUPS * 16)), "line outside configured groups")

  `ASSERT_RST(a_ascending, clk, rst, (out_valid && !out_stall && !last_dispatch) |=> (!out_valid || (line_number > $past(line_number))), "dispatch order not ascending")

endmodule

bind interrupt_pending_dispatcher_core ipd_checker #(
  .NUM_GROUPS (NUM_GROUPS)
) u_ipd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .device_type   (device_type),
  .device_number (device_number),
  .line_number   (line_number),
  .map_error     (map_error),
  .last_dispatch (last_dispatch)
);

`default_nettype wire

// ===== sim/interrupt_pending_dispatcher_core_tb.sv =====
// Testbench for interrupt_pending_dispatcher_core: directed table, then random capture/service
// bursts under four idling phases; each dispatch is checked against an in-bench predictor
// or a directed row's expectation. Depends on ipd_pkg and the dispatcher RTL only.
`timescale 1ns / 100ps

module interrupt_pending_dispatcher_core_tb;

  localparam int NUM_GROUPS             = 4;
  localparam int NUM_RANGES             = 4;
  localparam int QUIET_LIMIT            = 2000;
  localparam int SETTLE_CYCLES          = 100;
  localparam int RANDOM_ITEMS_PER_PHASE = 24;
  localparam int MAX_REPORTS            = 10;
  localparam int DIRECTED_ROWS          = 28;

  typedef enum logic [1:0] {
    RANGE_ENTRY_0, RANGE_ENTRY_1, RANGE_ENTRY_2, RANGE_ENTRY_3
  } range_reg_e;
  typedef enum logic {ROW_ITEM, ROW_TABLE} row_kind_e;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [7:0] dev_type;
    logic [7:0] dev_number;
    logic [5:0] line;
    logic       err;
    logic       last;
  } dispatch_t;

  typedef struct packed {
    row_kind_e  kind;
    logic       req;
    logic [1:0] grp;
    logic [15:0] flags;
    logic       has_exp;
    dispatch_t  exp;
  } stim_row_t;

  typedef logic [ipd_pkg::REG_W-1:0] range_set_t [ipd_pkg::REG_COUNT];

  localparam dispatch_t NO_DISPATCH = '0;

  localparam logic [ipd_pkg::REG_W-1:0] DIRECTED_TABLES [3][ipd_pkg::REG_COUNT] = '{
    '{24'h010000, 24'h02F010, 24'hFFFF28, 24'h03103C},
    '{24'h052008, 24'h000000, 24'h070000, 24'h0A3020},
    '{24'hFFFF00, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}
  };

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_ITEM,  ipd_pkg::REQ_CAPTURE, 2'd0, 16'h0001, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_SERVICE, 2'd3, 16'hFFFF, 1'b1, '{8'h00, 8'h00, 6'd0,  1'b1, 1'b1}},
    '{ROW_ITEM,  ipd_pkg::REQ_SERVICE, 2'd0, 16'h0000, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_CAPTURE, 2'd3, 16'h8000, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_SERVICE, 2'd0, 16'h0000, 1'b1, '{8'h00, 8'h00, 6'd63, 1'b1, 1'b1}},
    '{ROW_TABLE, ipd_pkg::REQ_CAPTURE, 2'd0, 16'h0000, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_CAPTURE, 2'd0, 16'hFFFF, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_CAPTURE, 2'd1, 16'hFFFF, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_CAPTURE, 2'd2, 16'hFFFF, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_CAPTURE, 2'd3, 16'hFFFF, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_SERVICE, 2'd0, 16'h0000, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_CAPTURE, 2'd3, 16'h8000, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_SERVICE, 2'd1, 16'h1234, 1'b1, '{8'h03, 8'h13, 6'd63, 1'b0, 1'b1}},
    '{ROW_ITEM,  ipd_pkg::REQ_CAPTURE, 2'd2, 16'h0200, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_SERVICE, 2'd0, 16'h0000, 1'b1, '{8'hFF, 8'h00, 6'd41, 1'b0, 1'b1}},
    '{ROW_ITEM,  ipd_pkg::REQ_CAPTURE, 2'd0, 16'h0001, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_CAPTURE, 2'd0, 16'h0001, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_SERVICE, 2'd0, 16'h0000, 1'b1, '{8'h01, 8'h00, 6'd0,  1'b0, 1'b1}},
    '{ROW_TABLE, ipd_pkg::REQ_CAPTURE, 2'd0, 16'h0000, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_CAPTURE, 2'd0, 16'h0181, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_CAPTURE, 2'd3, 16'hAAAA, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_CAPTURE, 2'd1, 16'h5555, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_SERVICE, 2'd2, 16'hFFFF, 1'b0, NO_DISPATCH},
    '{ROW_TABLE, ipd_pkg::REQ_CAPTURE, 2'd0, 16'h0000, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_CAPTURE, 2'd3, 16'h8000, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_SERVICE, 2'd0, 16'h0000, 1'b1, '{8'hFF, 8'h3E, 6'd63, 1'b0, 1'b1}},
    '{ROW_ITEM,  ipd_pkg::REQ_CAPTURE, 2'd1, 16'h0001, 1'b0, NO_DISPATCH},
    '{ROW_ITEM,  ipd_pkg::REQ_SERVICE, 2'd0, 16'h0000, 1'b1, '{8'hFF, 8'h0F, 6'd16, 1'b0, 1'b1}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = RANGE_ENTRY_0;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = ipd_pkg::REQ_CAPTURE;
  logic [1:0]  group_index = '0;
  logic [15:0] line_flags = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  device_type;
  logic [7:0]  device_number;
  logic [5:0]  line_number;
  logic        map_error;
  logic        last_dispatch;

  // predictor state
  logic [15:0]               pending_lines [NUM_GROUPS] = '{default: '0};
  logic [ipd_pkg::REG_W-1:0] range_regs [ipd_pkg::REG_COUNT] = '{default: '0};
  dispatch_t                 awaited_dispatches [$];

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int fails        = 0;
  int items_sent   = 0;
  int captures     = 0;
  int services     = 0;
  int dispatches_checked = 0;
  int tables_written     = 0;
  int quiet_cycles       = 0;

  interrupt_pending_dispatcher_core #(
    .NUM_GROUPS(NUM_GROUPS),
    .NUM_RANGES(NUM_RANGES)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .group_index  (group_index),
    .line_flags   (line_flags),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .device_type  (device_type),
    .device_number(device_number),
    .line_number  (line_number),
    .map_error    (map_error),
    .last_dispatch(last_dispatch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Walk the table from entry 0; an unused entry or one starting above the line ends it.
  function automatic dispatch_t map_to_device(logic [5:0] line);
    dispatch_t d;
    int        hit;
    logic      stop;
    d    = '0;
    hit  = -1;
    stop = 1'b0;
    d.line = line;
    for (int i = 0; i < NUM_RANGES; i++) begin
      if (!stop) begin
        if (range_regs[i][23:16] == 8'd0 || range_regs[i][7:0] > {2'b00, line}) begin
          stop = 1'b1;
        end else begin
          hit = i;
        end
      end
    end
    if (hit < 0) begin
      d.err = 1'b1;
    end else begin
      d.dev_type   = range_regs[hit][23:16];
      d.dev_number = range_regs[hit][15:8] + {2'b00, line} - range_regs[hit][7:0];
    end
    return d;
  endfunction

  function automatic range_set_t random_table();
    range_set_t t;
    int         start;
    start = ($urandom_range(99) < 70) ? 0 : $urandom_range(20);
    for (int i = 0; i < ipd_pkg::REG_COUNT; i++) begin
      t[i][23:16] = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
      t[i][15:8]  = 8'($urandom);
      t[i][7:0]   = 8'(start);
      start += $urandom_range(24, 1);
    end
    return t;
  endfunction

  function automatic logic [15:0] pick_line_flags();
    case ($urandom_range(5))
      0:       return 16'($urandom);
      1:       return 16'(1) << $urandom_range(15);
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom) & 16'($urandom) & 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic req, input logic [1:0] grp, input logic [15:0] flags,
                           input logic has_exp, input dispatch_t typed);
    dispatch_t scan [$];
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    group_index <= grp;
    line_flags  <= flags;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (req == ipd_pkg::REQ_CAPTURE) begin
      captures++;
      if (grp < NUM_GROUPS) pending_lines[grp] |= flags;
    end else begin
      services++;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        for (int b = 0; b < ipd_pkg::LINES_PER_GROUP; b++) begin
          if (pending_lines[g][b]) begin
            pending_lines[g][b] = 1'b0;
            scan.push_back(map_to_device(6'(g * ipd_pkg::LINES_PER_GROUP + b)));
          end
        end
      end
      if (scan.size() > 0) scan[scan.size() - 1].last = 1'b1;
      if (has_exp) begin
        awaited_dispatches.push_back(typed);
      end else begin
        foreach (scan[i]) awaited_dispatches.push_back(scan[i]);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_dispatches.size() != 0);
  endtask

  // Register writes only with the engine idle; captures and empty services leave no trace.
  task automatic write_table(input range_set_t vals);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < ipd_pkg::REG_COUNT; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= range_reg_e'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      range_regs[i] = vals[i];
    end
    cfg_write <= 1'b0;
    tables_written++;
  endtask

  initial begin
    int         table_sel;
    int         n;
    int         bursts;
    logic       paused;
    range_set_t tbl;
    table_sel = 0;
    paused    = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_TABLE) begin
        write_table(DIRECTED_TABLES[table_sel]);
        table_sel++;
      end else begin
        send_item(DIRECTED[r].req, DIRECTED[r].grp, DIRECTED[r].flags,
                  DIRECTED[r].has_exp, DIRECTED[r].exp);
      end
    end

    for (int phase = IDLE_NONE; phase <= IDLE_BOTH; phase++) begin
      case (phase)
        IDLE_NONE, IDLE_RECEIVER: tbl = random_table();
        IDLE_SENDER: begin
          foreach (tbl[i]) tbl[i] = 24'hFFFFFF;
        end
        default: begin
          foreach (tbl[i]) tbl[i] = 24'($urandom);
        end
      endcase
      write_table(tbl);
      case (phase)
        IDLE_SENDER: begin
          send_gap_pct = 76;
          stall_pct    = 0;
        end
        IDLE_RECEIVER: begin
          send_gap_pct = 0;
          stall_pct    = 76;
        end
        IDLE_BOTH: begin
          send_gap_pct = 12;
          stall_pct    = 12;
        end
        default: begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
      endcase

      n = 0;
      while (n < RANDOM_ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 80) begin
          bursts = $urandom_range(4, 1);
          repeat (bursts) begin
            send_item(ipd_pkg::REQ_CAPTURE, 2'($urandom_range(3)), pick_line_flags(),
                      1'b0, NO_DISPATCH);
            n++;
          end
          send_item(ipd_pkg::REQ_SERVICE, 2'($urandom_range(3)), 16'($urandom),
                    1'b0, NO_DISPATCH);
          n++;
          // hold the sender until the service run has fully drained
          if ($urandom_range(99) < 10 || (!paused && n >= RANDOM_ITEMS_PER_PHASE / 2)) begin
            wait_drained();
            paused = 1'b1;
          end
        end else begin
          send_item(1'($urandom_range(1)), 2'($urandom_range(3)), pick_line_flags(),
                    1'b0, NO_DISPATCH);
          n++;
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d transactions (%0d captures, %0d services) over %0d range tables",
             items_sent, captures, services, tables_written);
    $display("and four idling phases; %0d dispatches checked, %0d mismatches.",
             dispatches_checked, fails);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(posedge clk) begin : check_dispatches
    dispatch_t got;
    dispatch_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{device_type, device_number, line_number, map_error, last_dispatch};
        if (awaited_dispatches.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS) begin
            $display("unexpected dispatch: line %0d type %02h number %02h err %0b last %0b",
                     got.line, got.dev_type, got.dev_number, got.err, got.last);
          end
        end else begin
          want = awaited_dispatches.pop_front();
          dispatches_checked++;
          if (got.dev_type !== want.dev_type || got.dev_number !== want.dev_number ||
              got.line !== want.line || got.err !== want.err || got.last !== want.last) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
              $display("dispatch mismatch: expected line %0d type %02h number %02h err %0b last %0b",
                       want.line, want.dev_type, want.dev_number, want.err, want.last);
              $display("                   actual   line %0d type %02h number %02h err %0b last %0b",
                       got.line, got.dev_type, got.dev_number, got.err, got.last);
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d dispatches outstanding",
               QUIET_LIMIT, awaited_dispatches.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ipd_pkg.sv
hw/rtl/ipd_front.sv
hw/rtl/ipd_queue.sv
hw/rtl/ipd_back.sv
hw/rtl/interrupt_pending_dispatcher_core.sv
hw/rtl/ipd_checker.sv
sim/interrupt_pending_dispatcher_core_tb.sv
